FILE: rtl/arprx_pkg.sv
// Shared types and constants of the ARP receive table and reply block.
package arprx_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [7:0]  HW_LEN      = 8'd6;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_LEN   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [1:0] {
    STAT_HANDLED   = 2'd0,
    STAT_BAD_HW    = 2'd1,
    STAT_BAD_PROTO = 2'd2,
    STAT_UNSUP_OP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_UPDATED = 2'd1,
    ACT_ADDED   = 2'd2,
    ACT_FULL    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic        vld;
    logic        add_en;
    logic        hit;
    logic        free;
    logic [31:0] key;
    logic [47:0] mac;
  } tok_t;

  typedef struct packed {
    logic vld;
    logic commit;
  } resolve_t;

endpackage

FILE: rtl/arprx_in_if.sv
// Input channel carrying one parsed ARP packet per beat.
interface arprx_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hardware_type;
  logic [7:0]  hardware_size;
  logic [15:0] protocol_type;
  logic [7:0]  protocol_len;
  logic [15:0] opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;

  modport source (
    output valid, hardware_type, hardware_size, protocol_type, protocol_len,
           opcode, sender_mac, sender_ip, target_ip,
    input  ready
  );
  modport sink (
    input  valid, hardware_type, hardware_size, protocol_type, protocol_len,
           opcode, sender_mac, sender_ip, target_ip,
    output ready
  );
endinterface

FILE: rtl/arprx_out_if.sv
// Result channel carrying one status and reply descriptor per beat.
interface arprx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  table_action;
  logic        send_reply;
  logic [47:0] reply_target_mac;
  logic [31:0] reply_target_ip;

  modport source (
    output valid, status, table_action, send_reply, reply_target_mac, reply_target_ip,
    input  ready
  );
  modport sink (
    input  valid, status, table_action, send_reply, reply_target_mac, reply_target_ip,
    output ready
  );
endinterface

FILE: rtl/arprx_cell.sv
// One address table entry; checks the passing lookup token and hands it on.
module arprx_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  arprx_pkg::tok_t    tok_i,
  input  arprx_pkg::resolve_t res_i,
  output arprx_pkg::tok_t    tok_o
);

  logic            valid_r, valid_nxt;
  logic            tent_r, tent_nxt;
  logic [31:0]     ip_r, ip_nxt;
  logic [47:0]     mac_r, mac_nxt;
  arprx_pkg::tok_t tok_r, tok_nxt;
  logic            match;
  logic            claim;

  assign match = tok_i.vld & ~tok_i.hit & valid_r & (ip_r == tok_i.key);
  assign claim = tok_i.vld & tok_i.add_en & ~tok_i.free & ~valid_r;

  always_comb begin
    tok_nxt      = tok_i;
    tok_nxt.hit  = tok_i.hit | match;
    tok_nxt.free = tok_i.free | claim;
    valid_nxt    = valid_r | (res_i.vld & res_i.commit & tent_r);
    tent_nxt     = tent_r;
    ip_nxt       = ip_r;
    mac_nxt      = mac_r;
    if (res_i.vld) begin
      tent_nxt = 1'b0;
    end else if (claim) begin
      tent_nxt = 1'b1;
    end
    if (claim) begin
      ip_nxt  = tok_i.key;
      mac_nxt = tok_i.mac;
    end else if (match) begin
      mac_nxt = tok_i.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tent_r    <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tent_r  <= tent_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r  <= ip_nxt;
    mac_r <= mac_nxt;
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/arp_receive_table_and_reply.sv
// ARP receive path: checks each packet header, then walks a lookup token down a row of
// TABLE_ENTRIES table cells, one cell per cycle, updating a hit or claiming the lowest free
// slot, and commits an add once the token leaves the last cell. A valid Ethernet/IPv4
// packet stays in the scan state until its token leaves the last cell; a packet with a bad
// header skips the walk and goes straight to the finish state. One packet is in flight at
// a time; its result waits in an output register while the next packet is taken. The table
// starts empty after reset and needs no clearing pass.
module arp_receive_table_and_reply (
  input  logic              clk,
  input  logic              rst_n,
  arprx_in_if.sink          in_ch,
  arprx_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [47:0]       cfg_data
);

  localparam int N = arprx_pkg::TABLE_ENTRIES;

  arprx_pkg::state_t   state_r, state_nxt;
  logic [31:0]         own_ip_r;
  arprx_pkg::tok_t     tok_r, tok_nxt;
  arprx_pkg::tok_t     chain [N+1];
  arprx_pkg::resolve_t res;

  logic                bad_hw_r, bad_pr_r, addr_r, req_r, hit_r, free_r;
  logic [47:0]         smac_r;
  logic [31:0]         sip_r;

  logic                out_valid_r, out_valid_nxt;
  arprx_pkg::status_t  out_status_r, status_nxt;
  arprx_pkg::action_t  out_action_r, action_nxt;
  logic                out_reply_r;
  logic [47:0]         out_mac_r;
  logic [31:0]         out_ip_r;

  logic                accept, bad_hw, bad_pr, addressed, load;

  assign in_ch.ready = (state_r == arprx_pkg::S_IDLE);
  assign accept      = in_ch.valid & in_ch.ready;
  assign bad_hw      = (in_ch.hardware_type != arprx_pkg::HW_ETHERNET) |
                       (in_ch.hardware_size != arprx_pkg::HW_LEN);
  assign bad_pr      = (in_ch.protocol_type != arprx_pkg::PROTO_IPV4) |
                       (in_ch.protocol_len != arprx_pkg::PROTO_LEN);
  assign addressed   = (in_ch.target_ip == own_ip_r);
  assign load        = (state_r == arprx_pkg::S_FINISH) & (~out_valid_r | out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        arprx_pkg::CFG_OWN_IP: begin
          own_ip_r <= cfg_data[31:0];
        end
        arprx_pkg::CFG_OWN_MAC: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tok_nxt        = tok_r;
    tok_nxt.vld    = 1'b0;
    if (accept) begin
      tok_nxt.vld    = ~bad_hw & ~bad_pr;
      tok_nxt.add_en = addressed;
      tok_nxt.hit    = 1'b0;
      tok_nxt.free   = 1'b0;
      tok_nxt.key    = in_ch.sender_ip;
      tok_nxt.mac    = in_ch.sender_mac;
    end
  end

  assign chain[0] = tok_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    arprx_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .res_i (res),
      .tok_o (chain[g+1])
    );
  end

  assign res.vld    = chain[N].vld;
  assign res.commit = chain[N].add_en & ~chain[N].hit & chain[N].free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arprx_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (bad_hw | bad_pr) ? arprx_pkg::S_FINISH : arprx_pkg::S_SCAN;
        end
      end
      arprx_pkg::S_SCAN: begin
        if (chain[N].vld) begin
          state_nxt = arprx_pkg::S_FINISH;
        end
      end
      arprx_pkg::S_FINISH: begin
        if (load) begin
          state_nxt = arprx_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = arprx_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    status_nxt = arprx_pkg::STAT_HANDLED;
    action_nxt = arprx_pkg::ACT_NONE;
    priority if (bad_hw_r) begin
      status_nxt = arprx_pkg::STAT_BAD_HW;
    end else if (bad_pr_r) begin
      status_nxt = arprx_pkg::STAT_BAD_PROTO;
    end else begin
      if (addr_r && !req_r) begin
        status_nxt = arprx_pkg::STAT_UNSUP_OP;
      end
      priority if (hit_r) begin
        action_nxt = arprx_pkg::ACT_UPDATED;
      end else if (addr_r) begin
        action_nxt = free_r ? arprx_pkg::ACT_ADDED : arprx_pkg::ACT_FULL;
      end else begin
        action_nxt = arprx_pkg::ACT_NONE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arprx_pkg::S_IDLE;
      tok_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_r       <= tok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bad_hw_r <= bad_hw;
      bad_pr_r <= bad_pr;
      addr_r   <= addressed;
      req_r    <= (in_ch.opcode == arprx_pkg::OP_REQUEST);
      smac_r   <= in_ch.sender_mac;
      sip_r    <= in_ch.sender_ip;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else if (state_r == arprx_pkg::S_SCAN && chain[N].vld) begin
      hit_r  <= chain[N].hit;
      free_r <= chain[N].free;
    end
    if (load) begin
      out_status_r <= status_nxt;
      out_action_r <= action_nxt;
      out_reply_r  <= ~bad_hw_r & ~bad_pr_r & addr_r & req_r;
      out_mac_r    <= (~bad_hw_r & ~bad_pr_r & addr_r & req_r) ? smac_r : 48'd0;
      out_ip_r     <= (~bad_hw_r & ~bad_pr_r & addr_r & req_r) ? sip_r : 32'd0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.table_action     = out_action_r;
  assign out_ch.send_reply       = out_reply_r;
  assign out_ch.reply_target_mac = out_mac_r;
  assign out_ch.reply_target_ip  = out_ip_r;

endmodule
